>>> hdl/tsg_pkg.sv
// Shared types and constants for the tick-synced stereo gate.
// No dependencies; every other file of the block imports this package.
package tsg_pkg;

  localparam int SAMPLE_BITS_DEF = 24;

  localparam int OPEN_BITS = 16;
  localparam int STEP_BITS = 15;
  localparam int VOL_BITS  = 17;
  localparam int CFG_BITS  = 16;

  localparam logic [VOL_BITS-1:0]  VOL_FULL       = 17'd65536;
  localparam logic [VOL_BITS-1:0]  VOL_LOW_LIMIT  = 17'd655;
  localparam logic [VOL_BITS-1:0]  VOL_HIGH_LIMIT = 17'd64881;
  localparam logic [OPEN_BITS-1:0] TIMER_MAX      = 16'hFFFF;

  localparam logic [OPEN_BITS-1:0] OPEN_RESET = 16'd2048;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 15'd4096;

  typedef enum logic {
    CFG_OPEN_LENGTH = 1'b0,
    CFG_SLOPE_STEP  = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_TICK   = 1'b1
  } mode_e;

  typedef struct packed {
    logic scale_en;
    logic zero_en;
  } gate_ctl_t;

endpackage

>>> hdl/tsg_stream_if.sv
// Valid/ready stream interfaces for the gate's input items and result items.
// Depends on tsg_pkg for the default sample width.
interface tsg_in_if import tsg_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, mode, left_in, right_in, input ready);
  modport sink   (input valid, mode, left_in, right_in, output ready);
endinterface

interface tsg_out_if import tsg_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

>>> hdl/tsg_scaler.sv
// Scales one signed sample by the Q16 volume with round to nearest, ties upward.
// Depends on tsg_pkg for the volume width.
module tsg_scaler import tsg_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [VOL_BITS-1:0]    vol_i,
  output logic signed [SAMPLE_BITS-1:0] scaled_o
);

  localparam int PROD_BITS = SAMPLE_BITS + VOL_BITS + 1;

  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] rounded;

  assign prod     = PROD_BITS'(sample_i) * PROD_BITS'($signed({1'b0, vol_i}));
  assign rounded  = prod + PROD_BITS'(32768);
  assign scaled_o = rounded[SAMPLE_BITS+15:16];

endmodule

>>> hdl/tsg_gain_ctrl.sv
// Configuration registers, sample timer and volume ramp state of the gate.
// Depends on tsg_pkg for widths, limits, register indexes and the control struct.
module tsg_gain_ctrl import tsg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_e            cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i,
  input  logic                item_en_i,
  input  logic                mode_i,
  output gate_ctl_t           ctl_o,
  output logic [VOL_BITS-1:0] vol_o
);

  logic [OPEN_BITS-1:0] open_q;
  logic [STEP_BITS-1:0] step_q;
  logic [OPEN_BITS-1:0] timer_q, timer_d;
  logic [VOL_BITS-1:0]  vol_q, vol_d;
  logic                 muted_q, muted_d;
  logic                 ramp_q, ramp_d;

  logic [VOL_BITS:0]    vol_sum;
  logic [VOL_BITS-1:0]  vol_up;
  logic [VOL_BITS-1:0]  vol_down;
  logic                 thresh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= OPEN_RESET;
      step_q <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OPEN_LENGTH: open_q <= cfg_data_i;
        CFG_SLOPE_STEP:  step_q <= cfg_data_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign vol_sum  = {1'b0, vol_q} + (VOL_BITS+1)'(step_q);
  assign vol_up   = (vol_sum > (VOL_BITS+1)'(VOL_FULL)) ? VOL_FULL : vol_sum[VOL_BITS-1:0];
  assign vol_down = (vol_q > VOL_BITS'(step_q)) ? (vol_q - VOL_BITS'(step_q)) : '0;
  assign thresh   = ({1'b0, timer_q} + 17'd1) == {1'b0, open_q};

  always_comb begin
    timer_d = timer_q;
    vol_d   = vol_q;
    muted_d = muted_q;
    ramp_d  = ramp_q;
    ctl_o   = '0;
    if (mode_i == MODE_TICK) begin
      timer_d = '0;
      if (muted_q) begin
        muted_d = 1'b0;
        ramp_d  = 1'b1;
      end
    end else if (thresh) begin
      timer_d = open_q;
      if (ramp_q && vol_q < VOL_HIGH_LIMIT) begin
        ctl_o.scale_en = 1'b1;
        vol_d          = vol_up;
      end
      ramp_d  = 1'b1;
      muted_d = 1'b1;
    end else begin
      if (timer_q != TIMER_MAX) begin
        timer_d = timer_q + 16'd1;
      end
      if (!ramp_q) begin
        ctl_o.zero_en = muted_q;
      end else if (muted_q) begin
        if (vol_q > VOL_LOW_LIMIT) begin
          ctl_o.scale_en = 1'b1;
          vol_d          = vol_down;
          if (vol_down <= VOL_LOW_LIMIT) begin
            ramp_d = 1'b0;
          end
        end else begin
          ctl_o.zero_en = 1'b1;
          ramp_d        = 1'b0;
        end
      end else begin
        if (vol_q < VOL_HIGH_LIMIT) begin
          ctl_o.scale_en = 1'b1;
          vol_d          = vol_up;
          if (vol_up >= VOL_HIGH_LIMIT) begin
            ramp_d = 1'b0;
          end
        end else begin
          ramp_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q <= '0;
      vol_q   <= VOL_FULL;
      muted_q <= 1'b0;
      ramp_q  <= 1'b0;
    end else if (item_en_i) begin
      timer_q <= timer_d;
      vol_q   <= vol_d;
      muted_q <= muted_d;
      ramp_q  <= ramp_d;
    end
  end

  assign vol_o = vol_q;

`ifndef SYNTHESIS
  // A settled open gate sits at or above the upper limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ramp_q && !muted_q) |-> (vol_q >= VOL_HIGH_LIMIT))
    else $error("open gate settled below the upper volume limit");

  // A settled closed gate sits at or below the lower limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ramp_q && muted_q) |-> (vol_q <= VOL_LOW_LIMIT))
    else $error("closed gate settled above the lower volume limit");

  // A tick item always restarts the timer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_en_i && mode_i == MODE_TICK) |=> (timer_q == '0))
    else $error("sample timer not cleared by a tick item");
`endif

endmodule

>>> hdl/tick_synced_stereo_gate.sv
// Top level of the tick-synced stereo gate: input register, gain control,
// two channel scalers and the result register. Depends on tsg_pkg and the
// stream interfaces in tsg_stream_if.sv.

// Every item is first held in the input register. A sample item then moves on to the
// result register, where its result is offered; it waits in the input register while
// an earlier result there has not been taken. One item is taken in every cycle while
// the output side keeps up. Tick items leave the input register with no result and
// never wait on the output. The rate is set by the volume and timer update, which
// finishes within the cycle that one item leaves the input register, together
// with one multiplier per channel. Configuration writes take effect at the next
// edge and are meant to happen while no item is in flight.
module tick_synced_stereo_gate import tsg_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tsg_in_if.sink              in_ch_i,
  tsg_out_if.source           out_ch_o,
  input  logic                cfg_we_i,
  input  cfg_idx_e            cfg_idx_i,
  input  logic [CFG_BITS-1:0] cfg_data_i
);

  logic                          s1_v_q;
  logic                          s1_mode_q;
  logic signed [SAMPLE_BITS-1:0] s1_l_q, s1_r_q;
  logic                          out_v_q;
  logic signed [SAMPLE_BITS-1:0] out_l_q, out_r_q;
  logic signed [SAMPLE_BITS-1:0] out_l_d, out_r_d;
  logic signed [SAMPLE_BITS-1:0] scaled_l, scaled_r;
  logic                          s1_go;
  logic                          in_take;
  gate_ctl_t                     ctl;
  logic [VOL_BITS-1:0]           vol;

  assign s1_go   = s1_v_q && (s1_mode_q || !out_v_q || out_ch_o.ready);
  assign in_ch_i.ready = !s1_v_q || s1_go;
  assign in_take = in_ch_i.valid && in_ch_i.ready;

  tsg_gain_ctrl u_gain_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_en_i  (s1_go),
    .mode_i     (s1_mode_q),
    .ctl_o      (ctl),
    .vol_o      (vol)
  );

  tsg_scaler #(.SAMPLE_BITS(SAMPLE_BITS)) u_scaler_l (
    .sample_i (s1_l_q),
    .vol_i    (vol),
    .scaled_o (scaled_l)
  );

  tsg_scaler #(.SAMPLE_BITS(SAMPLE_BITS)) u_scaler_r (
    .sample_i (s1_r_q),
    .vol_i    (vol),
    .scaled_o (scaled_r)
  );

  always_comb begin
    out_l_d = s1_l_q;
    out_r_d = s1_r_q;
    if (ctl.zero_en) begin
      out_l_d = '0;
      out_r_d = '0;
    end else if (ctl.scale_en) begin
      out_l_d = scaled_l;
      out_r_d = scaled_r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go && s1_mode_q == MODE_SAMPLE) begin
        out_v_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_mode_q <= in_ch_i.mode;
      s1_l_q    <= in_ch_i.left_in;
      s1_r_q    <= in_ch_i.right_in;
    end
    if (s1_go && s1_mode_q == MODE_SAMPLE) begin
      out_l_q <= out_l_d;
      out_r_q <= out_r_d;
    end
  end

  assign out_ch_o.valid     = out_v_q;
  assign out_ch_o.left_out  = out_l_q;
  assign out_ch_o.right_out = out_r_q;

`ifndef SYNTHESIS
  // A tick item leaving the input register never creates a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_mode_q == MODE_TICK && (!out_v_q || out_ch_o.ready)) |=> !out_v_q)
    else $error("tick item produced a result");

  // Zeroing and scaling are never requested together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q |-> $onehot0({ctl.scale_en, ctl.zero_en}))
    else $error("gate control asks for both zero and scale");

  // A waiting result is not overwritten by the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ch_o.ready) |-> !(s1_go && s1_mode_q == MODE_SAMPLE))
    else $error("result register overwritten while stalled");
`endif

endmodule

>>> test/tick_synced_stereo_gate_tb.sv
// Self-checking testbench for the tick-synced stereo gate: a directed table, then random
// phases with varied open lengths and slopes, checked against a cycle-free gain model
// or typed row values. Depends on tsg_pkg, the stream interfaces and the top level of the block.
module tick_synced_stereo_gate_tb;
  import tsg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int unsigned PHASE_OPEN [7] = '{4, 1, 16, 65535, 40, 7, 2};
  localparam int unsigned PHASE_STEP [7] = '{16384, 1, 2000, 8192, 655, 16384, 5000};

  typedef logic signed [SB-1:0] sample_t;

  typedef struct {
    sample_t left;
    sample_t right;
  } gated_pair_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    mode_e     mode;
    cfg_idx_e  reg_idx;
    int        a;
    int        b;
    bit        typed;
    int        el;
    int        er;
  } plan_row_t;

  plan_row_t plan [34] = '{
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 8388607, -8388608, 1'b1, 8388607, -8388608},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, -8388608, 8388607, 1'b1, -8388608, 8388607},
    '{ROW_CFG,  MODE_SAMPLE, CFG_OPEN_LENGTH, 3, 0, 1'b0, 0, 0},
    '{ROW_CFG,  MODE_SAMPLE, CFG_SLOPE_STEP, 16384, 0, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_TICK,   CFG_OPEN_LENGTH, 123456, -654321, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 1000, -1000, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 2000, -2000, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 3000, -3000, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_TICK,   CFG_OPEN_LENGTH, 0, 0, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 4000, -4000, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 5000, -5000, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 6000, -6000, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 8388607, -8388608, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 8388607, -8388608, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 1234567, -7654321, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 3, -3, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 77777, -77777, 1'b1, 0, 0},
    '{ROW_ITEM, MODE_TICK,   CFG_OPEN_LENGTH, -1, -1, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 500000, -500000, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 8388607, -8388608, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, -8388608, 8388607, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 4194303, -4194304, 1'b0, 0, 0},
    '{ROW_CFG,  MODE_SAMPLE, CFG_SLOPE_STEP, 0, 0, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 8388607, -8388608, 1'b0, 0, 0},
    '{ROW_CFG,  MODE_SAMPLE, CFG_SLOPE_STEP, 32767, 0, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 99999, -99999, 1'b0, 0, 0},
    '{ROW_CFG,  MODE_SAMPLE, CFG_OPEN_LENGTH, 1, 0, 1'b0, 0, 0},
    '{ROW_CFG,  MODE_SAMPLE, CFG_SLOPE_STEP, 300, 0, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_TICK,   CFG_OPEN_LENGTH, 42, 42, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 8388607, -8388608, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 8388607, -8388608, 1'b1, 0, 0},
    '{ROW_CFG,  MODE_SAMPLE, CFG_OPEN_LENGTH, 0, 0, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_TICK,   CFG_OPEN_LENGTH, 0, 0, 1'b0, 0, 0},
    '{ROW_ITEM, MODE_SAMPLE, CFG_OPEN_LENGTH, 8388607, -8388608, 1'b0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_e cfg_idx;
  logic [CFG_BITS-1:0] cfg_data;

  tsg_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  tsg_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  tick_synced_stereo_gate #(.SAMPLE_BITS(SB)) u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_ch_i   (in_ch),
    .out_ch_o  (out_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  logic [OPEN_BITS-1:0] g_open;
  logic [STEP_BITS-1:0] g_step;
  logic [OPEN_BITS-1:0] g_timer;
  logic [VOL_BITS-1:0]  g_vol;
  logic                 g_muted;
  logic                 g_ramping;

  gated_pair_t gated_q[$];
  int err_cnt = 0;
  int burst_left = 0;
  bit long_hold_go = 1'b0;

  always #1 clk = ~clk;

  function automatic sample_t scale_sample(sample_t s, logic [VOL_BITS-1:0] v);
    longint prod;
    prod = longint'(s) * longint'(v);
    prod = (prod + 64'sd32768) >>> 16;
    return prod[SB-1:0];
  endfunction

  task automatic vol_up();
    logic [VOL_BITS:0] v;
    v = g_vol + g_step;
    g_vol = (v > VOL_FULL) ? VOL_FULL : v[VOL_BITS-1:0];
  endtask

  task automatic vol_down();
    g_vol = (g_vol > g_step) ? g_vol - g_step : '0;
  endtask

  task automatic gain_step(input mode_e mode, input sample_t l, input sample_t r,
                           output bit produced, output sample_t lo, output sample_t ro);
    lo = l;
    ro = r;
    produced = 1'b0;
    if (mode == MODE_TICK) begin
      g_timer = '0;
      if (g_muted) begin
        g_muted = 1'b0;
        g_ramping = 1'b1;
      end
    end else begin
      produced = 1'b1;
      if (g_timer < g_open && g_timer + 16'd1 == g_open) begin
        g_timer = g_open;
        if (g_ramping && g_vol < VOL_HIGH_LIMIT) begin
          lo = scale_sample(l, g_vol);
          ro = scale_sample(r, g_vol);
          vol_up();
        end
        g_ramping = 1'b1;
        g_muted = 1'b1;
      end else begin
        if (g_timer < TIMER_MAX) g_timer = g_timer + 16'd1;
        if (!g_ramping) begin
          if (g_muted) begin
            lo = '0;
            ro = '0;
          end
        end else if (g_muted) begin
          if (g_vol > VOL_LOW_LIMIT) begin
            lo = scale_sample(l, g_vol);
            ro = scale_sample(r, g_vol);
            vol_down();
            if (g_vol <= VOL_LOW_LIMIT) g_ramping = 1'b0;
          end else begin
            lo = '0;
            ro = '0;
            g_ramping = 1'b0;
          end
        end else begin
          if (g_vol < VOL_HIGH_LIMIT) begin
            lo = scale_sample(l, g_vol);
            ro = scale_sample(r, g_vol);
            vol_up();
          end
          if (g_vol >= VOL_HIGH_LIMIT) g_ramping = 1'b0;
        end
      end
    end
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(SB-1){1'b1}}};
      1: return {1'b1, {(SB-1){1'b0}}};
      2: return sample_t'($urandom_range(0, 8)) - sample_t'(4);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(string what);
    err_cnt++;
    $display("mismatch: %s", what);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance with valid still high.
  task automatic send_item(mode_e mode, sample_t l, sample_t r, bit typed,
                           sample_t el, sample_t er);
    int gap;
    bit produced;
    sample_t pl;
    sample_t pr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.left_in <= l;
    in_ch.right_in <= r;
    do @(posedge clk); while (!in_ch.ready);
    gain_step(mode, l, r, produced, pl, pr);
    if (produced) begin
      if (typed) gated_q.push_back('{el, er});
      else gated_q.push_back('{pl, pr});
    end
    @(negedge clk);
  endtask

  task automatic in_idle();
    in_ch.valid <= 1'b0;
  endtask

  // Ticks leave no result behind, so the wait goes on past an empty queue to cover one still in flight.
  task automatic wait_gate_drained();
    while (gated_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    if (idx == CFG_OPEN_LENGTH) g_open = data[OPEN_BITS-1:0];
    else g_step = data[STEP_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int until_tick;
    int tick_span;
    int waited;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_SAMPLE;
    in_ch.left_in <= '0;
    in_ch.right_in <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_OPEN_LENGTH;
    cfg_data <= '0;
    g_open = OPEN_RESET;
    g_step = STEP_RESET;
    g_timer = '0;
    g_vol = VOL_FULL;
    g_muted = 1'b0;
    g_ramping = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        in_idle();
        wait_gate_drained();
        cfg_write(plan[i].reg_idx, CFG_BITS'(plan[i].a));
      end else begin
        send_item(plan[i].mode, sample_t'(plan[i].a), sample_t'(plan[i].b), plan[i].typed,
                  sample_t'(plan[i].el), sample_t'(plan[i].er));
      end
    end

    foreach (PHASE_OPEN[p]) begin
      in_idle();
      wait_gate_drained();
      cfg_write(CFG_OPEN_LENGTH, CFG_BITS'(PHASE_OPEN[p]));
      cfg_write(CFG_SLOPE_STEP, CFG_BITS'(PHASE_STEP[p]));
      if (p == 2) long_hold_go = 1'b1;
      until_tick = 0;
      tick_span = (PHASE_OPEN[p] > 60) ? 120 : 2 * PHASE_OPEN[p] + 4;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == 4 && k == ITEMS_PER_PHASE / 2) begin
          in_idle();
          wait_gate_drained();
          @(negedge clk);
        end
        if (until_tick == 0 || $urandom_range(0, 31) == 0) begin
          until_tick = $urandom_range(0, tick_span);
          send_item(MODE_TICK, rand_sample(), rand_sample(), 1'b0, '0, '0);
        end else begin
          until_tick--;
          send_item(MODE_SAMPLE, rand_sample(), rand_sample(), 1'b0, '0, '0);
        end
      end
    end
    in_idle();

    waited = 0;
    while (gated_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (gated_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", gated_q.size()));
    end
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int style_left;
    int stall_style;
    int hold_left;
    bit long_done;
    out_ch.ready <= 1'b0;
    style_left = 0;
    stall_style = 0;
    hold_left = 0;
    long_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_done && long_hold_go) begin
        hold_left = 300;
        long_done = 1'b1;
      end
      if (style_left == 0) begin
        style_left = $urandom_range(16, 96);
        stall_style = $urandom_range(0, 3);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    gated_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (gated_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d %0d",
                                  out_ch.left_out, out_ch.right_out));
      end else begin
        want = gated_q.pop_front();
        if (out_ch.left_out !== want.left) begin
          report_mismatch($sformatf("left_out %0d, want %0d", out_ch.left_out, want.left));
        end
        if (out_ch.right_out !== want.right) begin
          report_mismatch($sformatf("right_out %0d, want %0d", out_ch.right_out, want.right));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
hdl/tsg_pkg.sv
hdl/tsg_stream_if.sv
hdl/tsg_scaler.sv
hdl/tsg_gain_ctrl.sv
hdl/tick_synced_stereo_gate.sv
test/tick_synced_stereo_gate_tb.sv
